// ===== hdl/iert_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iert_pkg: shared types and constants of the echo reply tracker
// Event codes, register indexes, timing constants and the records that
// travel between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package iert_pkg;

  localparam int DUP_WINDOW_DEF = 1024;
  localparam int QUEUE_DEPTH    = 8;
  localparam int CFG_AW         = 4;

  localparam logic [15:0] MY_ID_RST      = 16'd45007;
  localparam logic [15:0] PING_COUNT_RST = 16'd4;
  localparam logic [10:0] DATA_LEN_RST   = 11'd56;

  localparam logic [7:0]  ICMP_ECHO_REPLY   = 8'd0;
  localparam logic [7:0]  ICMP_ECHO_REQUEST = 8'd8;
  localparam logic [15:0] ICMP_HDR_LEN      = 16'd8;

  localparam logic [19:0] USEC_MAX      = 20'd999999;
  localparam logic [20:0] USEC_PER_SEC  = 21'd1000000;
  localparam logic [31:0] TRIP_PER_SEC  = 32'd10000;
  // floor(x / 100) == (x * DIV100_MUL) >> DIV100_SHIFT for x below 2^20.
  localparam logic [40:0] DIV100_MUL    = 41'd1342178;
  localparam int          DIV100_SHIFT  = 27;
  localparam int          TRIP_FRAC_W   = 14;
  localparam logic [31:0] TRIP_MIN_RST  = 32'h0000_FFFF;

  typedef enum logic [1:0] {
    REG_MY_ID      = 2'd0,
    REG_PING_COUNT = 2'd1,
    REG_DATA_LEN   = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    EV_SENT    = 3'd0,
    EV_SHORT   = 3'd1,
    EV_FOREIGN = 3'd2,
    EV_REPLY   = 3'd3,
    EV_DUP     = 3'd4,
    EV_REQUEST = 3'd5,
    EV_OTHER   = 3'd6
  } ev_t;

  // Classified item handed from the front end to the back end.
  typedef struct packed {
    ev_t         ev;
    logic [15:0] seq;
    logic [15:0] slot;
    logic [31:0] trip;
  } entry_t;

  typedef struct packed {
    ev_t         event_res;
    logic [15:0] out_sequence;
    logic [31:0] trip_time;
    logic [31:0] sent_total;
    logic [31:0] received_total;
    logic [31:0] duplicate_total;
    logic [31:0] min_trip;
    logic [31:0] max_trip;
    logic [31:0] trip_sum;
    logic        send_more;
    logic        all_received;
  } result_t;

endpackage

// ===== hdl/iert_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iert_in_if / iert_out_if: item channels of the echo reply tracker
// Valid/ready channels carrying one input event or one result item.
// ----------------------------------------------------------------------------
interface iert_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] packet_length;
  logic [7:0]  pkt_type;
  logic [15:0] icmp_ident;
  logic [15:0] icmp_sequence;
  logic [31:0] now_sec;
  logic [19:0] now_usec;
  logic [31:0] sent_sec;
  logic [19:0] sent_usec;

  modport source (
    output valid, kind, packet_length, pkt_type, icmp_ident, icmp_sequence,
           now_sec, now_usec, sent_sec, sent_usec,
    input  ready
  );
  modport sink (
    input  valid, kind, packet_length, pkt_type, icmp_ident, icmp_sequence,
           now_sec, now_usec, sent_sec, sent_usec,
    output ready
  );
endinterface

interface iert_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [15:0] out_sequence;
  logic [31:0] trip_time;
  logic [31:0] sent_total;
  logic [31:0] received_total;
  logic [31:0] duplicate_total;
  logic [31:0] min_trip;
  logic [31:0] max_trip;
  logic [31:0] trip_sum;
  logic        send_more;
  logic        all_received;

  modport source (
    output valid, event_res, out_sequence, trip_time, sent_total, received_total,
           duplicate_total, min_trip, max_trip, trip_sum, send_more, all_received,
    input  ready
  );
  modport sink (
    input  valid, event_res, out_sequence, trip_time, sent_total, received_total,
           duplicate_total, min_trip, max_trip, trip_sum, send_more, all_received,
    output ready
  );
endinterface

// ===== hdl/iert_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iert_front: event intake and classification
// Accepts events, classifies them, computes the round-trip time and the
// window slot in a three-stage pipeline and pushes the result to the queue.
// ----------------------------------------------------------------------------
module iert_front #(
  parameter int DUP_WINDOW = iert_pkg::DUP_WINDOW_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  iert_in_if.sink         in_item,
  input  logic [15:0]     my_id,
  input  logic [10:0]     data_len,
  input  logic            clr_busy,
  input  logic            q_pop,
  output logic            push,
  output iert_pkg::entry_t push_entry
);
  import iert_pkg::*;

  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [47:0] SLOT_RECIP =
    48'(((64'd1 << 32) + 64'(DUP_WINDOW) - 64'd1) / 64'(DUP_WINDOW));
  localparam logic [32:0] WIN = 33'(DUP_WINDOW);

  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic [15:0]      sent_seq_r;
  logic             accept;

  // Stage 1
  logic        s1_vld_r;
  ev_t         s1_ev_r;
  logic [15:0] s1_seq_r;
  logic [19:0] s1_nus_r, s1_sus_r;
  logic [31:0] s1_sdr_r;
  // Stage 2
  logic        s2_vld_r;
  ev_t         s2_ev_r;
  logic [15:0] s2_seq_r;
  logic [19:0] s2_udiff_r;
  logic [31:0] s2_sdiff_r;
  logic [15:0] s2_q_r;
  // Stage 3
  logic        s3_vld_r;
  ev_t         s3_ev_r;
  logic [15:0] s3_seq_r;
  logic [31:0] s3_psec_r;
  logic [TRIP_FRAC_W-1:0] s3_frac_r;
  logic [15:0] s3_slot_r;

  ev_t         ev_c;
  logic [15:0] min_len;
  logic [15:0] seq_c;
  logic        borrow;
  logic [20:0] udiff21;
  logic [47:0] qprod;
  logic [32:0] qwin;
  logic [16:0] slot17;
  logic [40:0] uprod;

  // Items in the pipeline or the queue; the queue can never overflow.
  assign in_item.ready = !clr_busy && (occ_r < OCC_W'(QUEUE_DEPTH));
  assign accept        = in_item.valid && in_item.ready;
  assign occ_nxt       = occ_r + OCC_W'(accept) - OCC_W'(q_pop);

  assign min_len = {5'b0, data_len} + ICMP_HDR_LEN;
  assign seq_c   = in_item.kind ? in_item.icmp_sequence : sent_seq_r + 16'd1;

  always_comb begin
    priority if (!in_item.kind) begin
      ev_c = EV_SENT;
    end else if (in_item.packet_length < min_len) begin
      ev_c = EV_SHORT;
    end else if (in_item.icmp_ident != my_id) begin
      ev_c = EV_FOREIGN;
    end else if (in_item.pkt_type == ICMP_ECHO_REPLY) begin
      ev_c = EV_REPLY;
    end else if (in_item.pkt_type == ICMP_ECHO_REQUEST) begin
      ev_c = EV_REQUEST;
    end else begin
      ev_c = EV_OTHER;
    end
  end

  assign borrow  = s1_nus_r < s1_sus_r;
  assign udiff21 = borrow ? ({1'b0, s1_nus_r} + USEC_PER_SEC - {1'b0, s1_sus_r})
                          : ({1'b0, s1_nus_r} - {1'b0, s1_sus_r});
  assign qprod   = 48'(s1_seq_r) * SLOT_RECIP;

  assign qwin   = 33'(s2_q_r) * WIN;
  assign slot17 = {1'b0, s2_seq_r} - qwin[16:0];
  assign uprod  = 41'(s2_udiff_r) * DIV100_MUL;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r      <= '0;
      sent_seq_r <= '0;
      s1_vld_r   <= 1'b0;
      s2_vld_r   <= 1'b0;
      s3_vld_r   <= 1'b0;
    end else begin
      occ_r    <= occ_nxt;
      s1_vld_r <= accept;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      if (accept && !in_item.kind) begin
        sent_seq_r <= seq_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_ev_r  <= ev_c;
    s1_seq_r <= seq_c;
    s1_nus_r <= (in_item.now_usec > USEC_MAX) ? USEC_MAX : in_item.now_usec;
    s1_sus_r <= (in_item.sent_usec > USEC_MAX) ? USEC_MAX : in_item.sent_usec;
    s1_sdr_r <= in_item.now_sec - in_item.sent_sec;

    s2_ev_r    <= s1_ev_r;
    s2_seq_r   <= s1_seq_r;
    s2_udiff_r <= udiff21[19:0];
    s2_sdiff_r <= s1_sdr_r - {31'b0, borrow};
    s2_q_r     <= qprod[47:32];

    s3_ev_r   <= s2_ev_r;
    s3_seq_r  <= s2_seq_r;
    s3_psec_r <= s2_sdiff_r * TRIP_PER_SEC;
    s3_frac_r <= uprod[DIV100_SHIFT +: TRIP_FRAC_W];
    s3_slot_r <= slot17[15:0];
  end

  assign push            = s3_vld_r;
  assign push_entry.ev   = s3_ev_r;
  assign push_entry.seq  = s3_seq_r;
  assign push_entry.slot = s3_slot_r;
  assign push_entry.trip = s3_psec_r + 32'(s3_frac_r);

endmodule

// ===== hdl/iert_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iert_queue: classified item queue
// Small register FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module iert_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  iert_pkg::entry_t push_entry,
  input  logic             pop,
  output logic             head_vld,
  output iert_pkg::entry_t head
);
  import iert_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  entry_t           slots_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

  assign head_vld = (cnt_r != '0);
  assign head     = slots_r[rd_ptr_r];

endmodule

// ===== hdl/iert_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iert_back: statistics update and result register
// Looks up the duplicate window, updates the counters and trip statistics
// and holds each result until the receiver takes it.
// ----------------------------------------------------------------------------
module iert_back #(
  parameter int DUP_WINDOW = iert_pkg::DUP_WINDOW_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_vld,
  input  iert_pkg::entry_t head,
  output logic             q_pop,
  input  logic [15:0]      ping_count,
  output logic             clr_busy,
  iert_out_if.source       out_item
);
  import iert_pkg::*;

  localparam int SLOT_W = $clog2(DUP_WINDOW);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(DUP_WINDOW - 1);

  logic seen_mem [DUP_WINDOW];

  logic              clr_busy_r;
  logic [SLOT_W-1:0] clr_idx_r;

  logic        b2_vld_r;
  entry_t      b2_entry_r;
  logic        rd_bit_r;
  logic        fwd_hit_r, fwd_bit_r;

  logic [31:0] sent_r, recv_r, dup_r, min_r, max_r, sum_r;
  logic [31:0] sent_nxt, recv_nxt, dup_nxt, min_nxt, max_nxt, sum_nxt;

  logic        out_vld_r;
  result_t     res_r, res_nxt;

  logic              b1_adv, b2_adv;
  logic [SLOT_W-1:0] rd_addr, wr_addr;
  logic              b2_we, b2_wd;
  logic              seen, is_reply, is_sent;

  assign b2_adv  = b2_vld_r && (!out_vld_r || out_item.ready);
  assign b1_adv  = head_vld && (!b2_vld_r || b2_adv);
  assign q_pop   = b1_adv;
  assign rd_addr = head.slot[SLOT_W-1:0];
  assign wr_addr = b2_entry_r.slot[SLOT_W-1:0];

  assign is_reply = (b2_entry_r.ev == EV_REPLY);
  assign is_sent  = (b2_entry_r.ev == EV_SENT);
  assign b2_we    = b2_adv && (is_reply || is_sent);
  assign b2_wd    = is_reply;
  // The item ahead may have written this slot at the edge the read was taken.
  assign seen     = fwd_hit_r ? fwd_bit_r : rd_bit_r;

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      seen_mem[clr_idx_r] <= 1'b0;
    end else if (b2_we) begin
      seen_mem[wr_addr] <= b2_wd;
    end
    if (b1_adv) begin
      rd_bit_r <= seen_mem[rd_addr];
    end
  end

  always_comb begin
    sent_nxt = sent_r + 32'(is_sent);
    recv_nxt = recv_r + 32'(is_reply && !seen);
    dup_nxt  = dup_r + 32'(is_reply && seen);
    min_nxt  = (is_reply && (b2_entry_r.trip < min_r)) ? b2_entry_r.trip : min_r;
    max_nxt  = (is_reply && (b2_entry_r.trip > max_r)) ? b2_entry_r.trip : max_r;
    sum_nxt  = is_reply ? sum_r + b2_entry_r.trip : sum_r;

    res_nxt.event_res       = (is_reply && seen) ? EV_DUP : b2_entry_r.ev;
    res_nxt.out_sequence    = is_sent ? b2_entry_r.seq : 16'd0;
    res_nxt.trip_time       = is_reply ? b2_entry_r.trip : 32'd0;
    res_nxt.sent_total      = sent_nxt;
    res_nxt.received_total  = recv_nxt;
    res_nxt.duplicate_total = dup_nxt;
    res_nxt.min_trip        = min_nxt;
    res_nxt.max_trip        = max_nxt;
    res_nxt.trip_sum        = sum_nxt;
    res_nxt.send_more       = is_sent &&
                              ((ping_count == 16'd0) || (sent_nxt < {16'd0, ping_count}));
    res_nxt.all_received    = (ping_count != 16'd0) && (recv_nxt >= {16'd0, ping_count});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
      b2_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      sent_r     <= '0;
      recv_r     <= '0;
      dup_r      <= '0;
      min_r      <= TRIP_MIN_RST;
      max_r      <= '0;
      sum_r      <= '0;
    end else begin
      if (clr_busy_r) begin
        clr_idx_r <= clr_idx_r + 1'b1;
        if (clr_idx_r == SLOT_LAST) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (b1_adv) begin
        b2_vld_r <= 1'b1;
      end else if (b2_adv) begin
        b2_vld_r <= 1'b0;
      end
      if (b2_adv) begin
        out_vld_r <= 1'b1;
        sent_r    <= sent_nxt;
        recv_r    <= recv_nxt;
        dup_r     <= dup_nxt;
        min_r     <= min_nxt;
        max_r     <= max_nxt;
        sum_r     <= sum_nxt;
      end else if (out_item.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b1_adv) begin
      b2_entry_r <= head;
      fwd_hit_r  <= b2_we && (wr_addr == rd_addr);
      fwd_bit_r  <= b2_wd;
    end
    if (b2_adv) begin
      res_r <= res_nxt;
    end
  end

  assign clr_busy                = clr_busy_r;
  assign out_item.valid          = out_vld_r;
  assign out_item.event_res      = res_r.event_res;
  assign out_item.out_sequence   = res_r.out_sequence;
  assign out_item.trip_time      = res_r.trip_time;
  assign out_item.sent_total     = res_r.sent_total;
  assign out_item.received_total = res_r.received_total;
  assign out_item.duplicate_total = res_r.duplicate_total;
  assign out_item.min_trip       = res_r.min_trip;
  assign out_item.max_trip       = res_r.max_trip;
  assign out_item.trip_sum       = res_r.trip_sum;
  assign out_item.send_more      = res_r.send_more;
  assign out_item.all_received   = res_r.all_received;

endmodule

// ===== hdl/icmp_echo_reply_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icmp_echo_reply_tracker: sender-side ping statistics
// Counts sent requests, checks received ICMP packets, measures round-trip
// times and flags duplicate replies.
// ----------------------------------------------------------------------------
// Usage:
//   in_item carries one event: a request being sent (kind 0) or a received
//   ICMP packet (kind 1) with its reception and echoed send timestamps.
//   out_item returns exactly one result item per event, in order, with the
//   event class and the statistics after the event.
//   The APB port sets the identifier, the ping count and the payload length;
//   write it only while no event is in flight.
// Timing:
//   One event per cycle is accepted and produced as long as out_item is
//   taken. A result passes three front stages, the queue, and the window
//   lookup in the back end, whose single memory read is the per-item step.
// Reset and stalls:
//   After reset the duplicate window is cleared one slot per cycle, and
//   in_item.ready stays low until it is clear. When the receiver stalls
//   the last result is held, and up to 9 further events are still taken (one
//   into the window lookup stage, eight into the pipeline and queue) before
//   in_item.ready drops.
// ----------------------------------------------------------------------------
module icmp_echo_reply_tracker #(
  parameter int DUP_WINDOW = iert_pkg::DUP_WINDOW_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  iert_in_if.sink                     in_item,
  iert_out_if.source                  out_item,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [iert_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import iert_pkg::*;

  logic [15:0] my_id_r;
  logic [15:0] ping_count_r;
  logic [10:0] data_len_r;
  logic        cfg_we;
  reg_idx_t    cfg_idx;

  logic        clr_busy;
  logic        q_pop;
  logic        push;
  entry_t      push_entry;
  logic        head_vld;
  entry_t      head;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      my_id_r      <= MY_ID_RST;
      ping_count_r <= PING_COUNT_RST;
      data_len_r   <= DATA_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_MY_ID:      my_id_r      <= pwdata[15:0];
        REG_PING_COUNT: ping_count_r <= pwdata[15:0];
        REG_DATA_LEN:   data_len_r   <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MY_ID:      prdata = {16'd0, my_id_r};
      REG_PING_COUNT: prdata = {16'd0, ping_count_r};
      REG_DATA_LEN:   prdata = {21'd0, data_len_r};
      default:        prdata = 32'd0;
    endcase
  end

  iert_front #(.DUP_WINDOW(DUP_WINDOW)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .my_id      (my_id_r),
    .data_len   (data_len_r),
    .clr_busy   (clr_busy),
    .q_pop      (q_pop),
    .push       (push),
    .push_entry (push_entry)
  );

  iert_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .head_vld   (head_vld),
    .head       (head)
  );

  iert_back #(.DUP_WINDOW(DUP_WINDOW)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_vld   (head_vld),
    .head       (head),
    .q_pop      (q_pop),
    .ping_count (ping_count_r),
    .clr_busy   (clr_busy),
    .out_item   (out_item)
  );

endmodule

// ===== hdl/iert_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iert_checker: port-level checks of the echo reply tracker
// Watches the item channels and reports inconsistent result items.
// ----------------------------------------------------------------------------
module iert_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  event_res,
  input logic [15:0] out_sequence,
  input logic [31:0] trip_time,
  input logic [31:0] min_trip,
  input logic [31:0] max_trip,
  input logic [31:0] trip_sum,
  input logic        send_more
);
  import iert_pkg::*;

  // The window is being cleared right after reset, so no item is taken.
  a_no_intake_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("item intake enabled during window clearing");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(event_res) && $stable(trip_sum))
    else $error("stalled result item changed");

  a_trip_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (event_res == EV_REPLY || event_res == EV_DUP)
      |-> min_trip <= trip_time && trip_time <= max_trip)
    else $error("reply trip time outside min/max statistics");

  a_no_trip_for_other: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_res != EV_REPLY && event_res != EV_DUP |-> trip_time == 32'd0)
    else $error("trip time reported for a non-reply item");

  a_send_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_res != EV_SENT |-> out_sequence == 16'd0 && !send_more)
    else $error("send fields set on a receive item");

endmodule

bind icmp_echo_reply_tracker iert_checker u_iert_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_item.ready),
  .out_valid    (out_item.valid),
  .out_ready    (out_item.ready),
  .event_res    (out_item.event_res),
  .out_sequence (out_item.out_sequence),
  .trip_time    (out_item.trip_time),
  .min_trip     (out_item.min_trip),
  .max_trip     (out_item.max_trip),
  .trip_sum     (out_item.trip_sum),
  .send_more    (out_item.send_more)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: ping statistics tracker check
// Drives send and receive events through the item channel and compares every
// result item with a prediction kept in a small scoreboard class. It writes
// the identifier, ping count and payload length between phases, stalls both
// channels at random, and holds off the receiver once to fill the block.
// ----------------------------------------------------------------------------
module testbench;
  import iert_pkg::*;

  typedef struct packed {
    logic        kind;
    logic [15:0] packet_length;
    logic [7:0]  pkt_type;
    logic [15:0] icmp_ident;
    logic [15:0] icmp_sequence;
    logic [31:0] now_sec;
    logic [19:0] now_usec;
    logic [31:0] sent_sec;
    logic [19:0] sent_usec;
  } ping_item_t;

  class ping_scoreboard;
    logic [15:0] my_id;
    logic [15:0] ping_count;
    logic [10:0] data_len;
    bit          slot_seen [DUP_WINDOW_DEF];
    logic [31:0] tx_count;
    logic [31:0] rx_count;
    logic [31:0] dup_count;
    logic [31:0] rtt_min;
    logic [31:0] rtt_max;
    logic [31:0] rtt_sum;
    result_t     expected_results[$];
    int          errors;

    function new();
      my_id      = MY_ID_RST;
      ping_count = PING_COUNT_RST;
      data_len   = DATA_LEN_RST;
      foreach (slot_seen[i]) slot_seen[i] = 1'b0;
      tx_count  = '0;
      rx_count  = '0;
      dup_count = '0;
      rtt_min   = TRIP_MIN_RST;
      rtt_max   = '0;
      rtt_sum   = '0;
      errors    = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] value);
      case (idx)
        REG_MY_ID:      my_id      = value[15:0];
        REG_PING_COUNT: ping_count = value[15:0];
        REG_DATA_LEN:   data_len   = value[10:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    task report(string msg);
      // Keep the log short when the block goes badly wrong.
      if (errors < 100) $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
    endtask

    // Round-trip time in 0.1 ms units, with saturated microseconds and a borrow.
    function logic [31:0] trip_of(ping_item_t it);
      logic [31:0] nus;
      logic [31:0] sus;
      logic [31:0] sdiff;
      logic [31:0] udiff;
      nus   = (it.now_usec > USEC_MAX) ? {12'd0, USEC_MAX} : {12'd0, it.now_usec};
      sus   = (it.sent_usec > USEC_MAX) ? {12'd0, USEC_MAX} : {12'd0, it.sent_usec};
      sdiff = it.now_sec - it.sent_sec;
      if (nus < sus) begin
        sdiff = sdiff - 32'd1;
        udiff = nus + {11'd0, USEC_PER_SEC} - sus;
      end else begin
        udiff = nus - sus;
      end
      return sdiff * TRIP_PER_SEC + udiff / 32'd100;
    endfunction

    // Advance the tracker state by one accepted item and queue its result.
    function void note_item(ping_item_t it);
      result_t r;
      int      slot;
      r = '0;
      if (it.kind == 1'b0) begin
        tx_count++;
        r.out_sequence = tx_count[15:0];
        slot_seen[int'(tx_count[15:0]) % DUP_WINDOW_DEF] = 1'b0;
        r.send_more = (ping_count == 16'd0) || (tx_count < {16'd0, ping_count});
        r.event_res = EV_SENT;
      end else if (int'(it.packet_length) < int'(data_len) + 8) begin
        r.event_res = EV_SHORT;
      end else if (it.icmp_ident != my_id) begin
        r.event_res = EV_FOREIGN;
      end else if (it.pkt_type == ICMP_ECHO_REPLY) begin
        slot = int'(it.icmp_sequence) % DUP_WINDOW_DEF;
        r.trip_time = trip_of(it);
        rtt_sum = rtt_sum + r.trip_time;
        if (r.trip_time < rtt_min) rtt_min = r.trip_time;
        if (r.trip_time > rtt_max) rtt_max = r.trip_time;
        if (slot_seen[slot]) begin
          dup_count++;
          r.event_res = EV_DUP;
        end else begin
          slot_seen[slot] = 1'b1;
          rx_count++;
          r.event_res = EV_REPLY;
        end
      end else if (it.pkt_type == ICMP_ECHO_REQUEST) begin
        r.event_res = EV_REQUEST;
      end else begin
        r.event_res = EV_OTHER;
      end
      r.sent_total      = tx_count;
      r.received_total  = rx_count;
      r.duplicate_total = dup_count;
      r.min_trip        = rtt_min;
      r.max_trip        = rtt_max;
      r.trip_sum        = rtt_sum;
      r.all_received    = (ping_count != 16'd0) && (rx_count >= {16'd0, ping_count});
      expected_results.push_back(r);
    endfunction

    task cmp_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("%s: got 0x%08h, expected 0x%08h", name, got, want));
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        report("result item with no item outstanding");
        return;
      end
      want = expected_results.pop_front();
      cmp_field("event_res", 32'(got.event_res), 32'(want.event_res));
      cmp_field("out_sequence", 32'(got.out_sequence), 32'(want.out_sequence));
      cmp_field("trip_time", got.trip_time, want.trip_time);
      cmp_field("sent_total", got.sent_total, want.sent_total);
      cmp_field("received_total", got.received_total, want.received_total);
      cmp_field("duplicate_total", got.duplicate_total, want.duplicate_total);
      cmp_field("min_trip", got.min_trip, want.min_trip);
      cmp_field("max_trip", got.max_trip, want.max_trip);
      cmp_field("trip_sum", got.trip_sum, want.trip_sum);
      cmp_field("send_more", 32'(got.send_more), 32'(want.send_more));
      cmp_field("all_received", 32'(got.all_received), 32'(want.all_received));
    endtask
  endclass

  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 215;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  iert_in_if  in_ch ();
  iert_out_if out_ch ();

  ping_scoreboard sb;
  ping_item_t     last_reply;
  int             tx_idle_pct;
  int             rx_idle_pct;
  bit             hold_req;
  int             idle_cycles;

  icmp_echo_reply_tracker u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_ch),
    .out_item (out_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic ping_item_t rand_item();
    logic [191:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return raw[$bits(ping_item_t)-1:0];
  endfunction

  function automatic ping_item_t mk_send();
    ping_item_t it;
    it = rand_item();
    it.kind = 1'b0;
    return it;
  endfunction

  function automatic ping_item_t mk_rx(logic [15:0] plen, logic [7:0] typ,
                                       logic [15:0] ident, logic [15:0] seq,
                                       logic [31:0] ns, logic [19:0] nus,
                                       logic [31:0] ss, logic [19:0] sus);
    ping_item_t it;
    it = '{1'b1, plen, typ, ident, seq, ns, nus, ss, sus};
    return it;
  endfunction

  // Sends and replies to recent requests with realistic times; the rest is
  // repeated replies and unconstrained packets.
  function automatic ping_item_t next_item();
    ping_item_t it;
    int         pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      it = mk_send();
    end else if (pick < 75) begin
      it = rand_item();
      it.kind          = 1'b1;
      it.packet_length = 16'(int'(sb.data_len) + 8 + $urandom_range(0, 64));
      it.pkt_type      = ICMP_ECHO_REPLY;
      it.icmp_ident    = sb.my_id;
      it.icmp_sequence = sb.tx_count[15:0] - 16'($urandom_range(0, 3));
      it.now_sec       = it.sent_sec + $urandom_range(0, 3);
      it.now_usec      = 20'($urandom_range(0, 999999));
      it.sent_usec     = 20'($urandom_range(0, 999999));
      last_reply = it;
    end else if (pick < 85) begin
      it = last_reply;
    end else begin
      it = rand_item();
      if ($urandom_range(0, 1) == 0) it.icmp_ident = sb.my_id;
      case ($urandom_range(0, 2))
        0: it.pkt_type = ICMP_ECHO_REPLY;
        1: it.pkt_type = ICMP_ECHO_REQUEST;
        default: ;
      endcase
    end
    return it;
  endfunction

  task automatic cfg_write(reg_idx_t idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  task automatic push_item(ping_item_t it);
    int gap;
    in_ch.valid         <= 1'b1;
    in_ch.kind          <= it.kind;
    in_ch.packet_length <= it.packet_length;
    in_ch.pkt_type      <= it.pkt_type;
    in_ch.icmp_ident    <= it.icmp_ident;
    in_ch.icmp_sequence <= it.icmp_sequence;
    in_ch.now_sec       <= it.now_sec;
    in_ch.now_usec      <= it.now_usec;
    in_ch.sent_sec      <= it.sent_sec;
    in_ch.sent_usec     <= it.sent_usec;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_item(it);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering items until every result is back, then let the pipe settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Receiver: random ready with runs of either level, plus one long hold-off.
  always @(posedge clk) begin : rx_ready
    int  hold_left;
    int  run_left;
    bit  rx_on;
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      if (run_left > 0) begin
        run_left--;
      end else begin
        rx_on = $urandom_range(0, 99) >= rx_idle_pct;
        run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
      end
      out_ch.ready <= rx_on;
    end
  end

  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.event_res       = ev_t'(out_ch.event_res);
      got.out_sequence    = out_ch.out_sequence;
      got.trip_time       = out_ch.trip_time;
      got.sent_total      = out_ch.sent_total;
      got.received_total  = out_ch.received_total;
      got.duplicate_total = out_ch.duplicate_total;
      got.min_trip        = out_ch.min_trip;
      got.max_trip        = out_ch.max_trip;
      got.trip_sum        = out_ch.trip_sum;
      got.send_more       = out_ch.send_more;
      got.all_received    = out_ch.all_received;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    logic [15:0] id;
    sb = new();
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = 1'b0;
    in_ch.packet_length = '0;
    in_ch.pkt_type = '0;
    in_ch.icmp_ident = '0;
    in_ch.icmp_sequence = '0;
    in_ch.now_sec = '0;
    in_ch.now_usec = '0;
    in_ch.sent_sec = '0;
    in_ch.sent_usec = '0;
    out_ch.ready = 1'b0;
    hold_req = 1'b0;
    idle_cycles = 0;
    tx_idle_pct = 20;
    rx_idle_pct = 20;
    last_reply = mk_rx(16'd64, ICMP_ECHO_REPLY, MY_ID_RST, 16'd1, 32'd1, 20'd0, 32'd1, 20'd0);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset settings: minimum length is 64 bytes.
    id = MY_ID_RST;
    push_item(mk_send());
    push_item(mk_rx(16'd64, 8'd0, id, 16'd1, 32'd100, 20'd500000, 32'd99, 20'd400000));
    push_item(mk_rx(16'd64, 8'd0, id, 16'd1, 32'd100, 20'd500000, 32'd99, 20'd400000));
    push_item(mk_rx(16'd63, 8'd0, id, 16'd1, 32'd100, 20'd0, 32'd100, 20'd0));
    push_item(mk_rx(16'hFFFF, 8'd0, 16'd0, 16'd2, 32'd100, 20'd0, 32'd100, 20'd0));
    push_item(mk_rx(16'd64, 8'd8, id, 16'd2, 32'd1, 20'd0, 32'd1, 20'd0));
    push_item(mk_rx(16'd64, 8'hFF, id, 16'd2, 32'd1, 20'd0, 32'd1, 20'd0));
    push_item(mk_send());
    // Borrow of one second from the microseconds.
    push_item(mk_rx(16'd64, 8'd0, id, 16'd2, 32'd10, 20'd100, 32'd9, 20'd999999));
    // Sequence 1025 lands in the slot of sequence 1.
    push_item(mk_rx(16'd64, 8'd0, id, 16'd1025, 32'd7, 20'd5000, 32'd7, 20'd0));
    // Microseconds above the legal range saturate.
    push_item(mk_rx(16'd64, 8'd0, id, 16'd3, 32'd5, 20'hFFFFF, 32'd5, 20'hFFFFF));
    push_item(mk_rx(16'd64, 8'd0, id, 16'd4, 32'd5, 20'hFFFFF, 32'd5, 20'd0));
    push_item(mk_rx(16'd64, 8'd0, id, 16'd5, 32'd0, 20'd0, 32'hFFFFFFFF, 20'd999999));
    push_item(mk_rx(16'd64, 8'd0, id, 16'd6, 32'hFFFFFFFF, 20'd999999, 32'd0, 20'd0));
    push_item(mk_send());
    push_item(mk_rx(16'd64, 8'd0, id, 16'd3, 32'd2, 20'd300, 32'd2, 20'd100));
    push_item(mk_send());
    push_item(mk_send());
    push_item(mk_rx(16'd0, 8'd0, id, 16'd0, 32'd0, 20'd0, 32'd0, 20'd0));
    push_item(mk_rx(16'hFFFF, 8'd0, 16'hFFFF, 16'hFFFF, 32'd0, 20'd0, 32'd0, 20'd0));
    push_item(mk_rx(16'hFFFF, 8'd0, id, 16'd0, 32'd3, 20'd0, 32'd1, 20'd0));

    for (int p = 0; p < 6; p++) begin
      drain();
      case (p)
        0: begin
          cfg_write(REG_MY_ID, 32'd0);
          cfg_write(REG_PING_COUNT, 32'd0);
          cfg_write(REG_DATA_LEN, 32'd0);
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
        1: begin
          cfg_write(REG_MY_ID, 32'hFFFF);
          cfg_write(REG_PING_COUNT, 32'hFFFF);
          cfg_write(REG_DATA_LEN, 32'h7FF);
          tx_idle_pct = 30;
          rx_idle_pct = 30;
          hold_req = 1'b1;
        end
        2: begin
          cfg_write(REG_MY_ID, $urandom_range(0, 65535));
          cfg_write(REG_PING_COUNT, $urandom_range(1, 12));
          cfg_write(REG_DATA_LEN, $urandom_range(0, 1472));
          tx_idle_pct = 50;
          rx_idle_pct = 10;
        end
        3: begin
          cfg_write(REG_MY_ID, $urandom_range(0, 65535));
          cfg_write(REG_PING_COUNT, 32'd1);
          cfg_write(REG_DATA_LEN, $urandom_range(0, 2047));
          tx_idle_pct = 10;
          rx_idle_pct = 50;
        end
        4: begin
          cfg_write(REG_MY_ID, $urandom_range(0, 65535));
          cfg_write(REG_PING_COUNT, $urandom_range(0, 65535));
          cfg_write(REG_DATA_LEN, 32'd1472);
          tx_idle_pct = 25;
          rx_idle_pct = 25;
        end
        default: begin
          cfg_write(REG_MY_ID, {16'd0, MY_ID_RST});
          cfg_write(REG_PING_COUNT, {16'd0, PING_COUNT_RST});
          cfg_write(REG_DATA_LEN, {21'd0, DATA_LEN_RST});
          tx_idle_pct = 15;
          rx_idle_pct = 15;
        end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Once, the sender waits for every outstanding result mid-phase.
        if (p == 2 && i == PHASE_ITEMS / 2) drain();
        push_item(next_item());
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
